// ===== sv/crm_pkg.sv =====
// shared types and constants for the convolution, relu and max-pool unit
// no dependencies
package crm_pkg;

    localparam int MaxRows     = 32;
    localparam int MaxCols     = 32;
    localparam int MaxChannels = 4;
    localparam int MaxKernel   = 5;

    localparam int ImgDepth = MaxChannels * MaxRows * MaxCols;
    localparam int KerDepth = MaxChannels * MaxKernel * MaxKernel;
    localparam int ImgAw    = $clog2(ImgDepth);
    localparam int KerAw    = $clog2(KerDepth);

    // request kinds
    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_POOL   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_BIAS     = 3'd0;
    localparam logic [2:0] REG_ROWS     = 3'd1;
    localparam logic [2:0] REG_COLS     = 3'd2;
    localparam logic [2:0] REG_CHANNELS = 3'd3;
    localparam logic [2:0] REG_KERNEL   = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic       start;     // load request fields, clear position
        logic       pos_init;  // acc = bias, clear tap counters
        logic       tap_step;  // issue one tap read and advance counters
        logic       mac;       // multiply-accumulate the registered reads
        logic       pos_done;  // fold result into running maximum
        logic       out_load;  // move maximum to output register
    } crm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic taps_last;  // current tap is the last of the position
        logic pos_last;   // current position is the fourth
    } crm_stat_t;

endpackage

// ===== sv/crm_datapath.sv =====
// datapath: stores, tap address generation, shared multiply-accumulate and pooling
// depends on crm_pkg
module crm_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  crm_pkg::crm_cmd_t   cmd,
    output crm_pkg::crm_stat_t  stat,
    input  logic                wr_img,
    input  logic                wr_ker,
    input  logic [1:0]          in_channel,
    input  logic [4:0]          in_row,
    input  logic [4:0]          in_col,
    input  logic signed [15:0]  in_value,
    input  logic signed [31:0]  bias,
    input  logic [5:0]          rows,
    input  logic [5:0]          cols,
    input  logic [2:0]          chans,
    input  logic [2:0]          ksize,
    output logic [14:0]         max_value,
    output logic [2:0]          max_index
);

    logic signed [15:0] img_mem [crm_pkg::ImgDepth];
    logic signed [15:0] ker_mem [crm_pkg::KerDepth];

    logic [4:0]  prow_reg, pcol_reg;
    logic [1:0]  pos_reg;
    logic [1:0]  ch_reg;
    logic [2:0]  fr_reg, fc_reg;
    logic        rd_valid_reg;
    logic signed [15:0] pix_reg, wt_reg;
    logic signed [31:0] prod_reg;
    logic        prod_valid_reg;
    logic signed [47:0] acc_reg;
    logic [14:0] best_reg;
    logic        best_any_reg;
    logic [2:0]  best_idx_reg;
    logic [14:0] max_value_reg;
    logic [2:0]  max_index_reg;

    // tap position in map coordinates
    logic signed [7:0] rr, cc;
    logic [2:0]        half;
    logic              tap_in;
    logic [crm_pkg::ImgAw-1:0] img_addr;
    logic [crm_pkg::KerAw-1:0] ker_addr;
    logic              last_fc, last_fr, last_ch;

    assign half = ksize >> 1;
    assign rr = $signed({2'b0, prow_reg, pos_reg[1]}) + $signed({5'b0, fr_reg})
                - $signed({5'b0, half});
    assign cc = $signed({2'b0, pcol_reg, pos_reg[0]}) + $signed({5'b0, fc_reg})
                - $signed({5'b0, half});
    assign tap_in = (rr >= 0) && (rr < $signed({2'b0, rows}))
                 && (cc >= 0) && (cc < $signed({2'b0, cols}));
    assign img_addr = {ch_reg, rr[4:0], cc[4:0]};
    assign ker_addr = crm_pkg::KerAw'((ch_reg * crm_pkg::MaxKernel + fr_reg)
                      * crm_pkg::MaxKernel + fc_reg);

    assign last_fc = (fc_reg == ksize - 3'd1);
    assign last_fr = (fr_reg == ksize - 3'd1);
    assign last_ch = ({1'b0, ch_reg} == chans - 3'd1);
    assign stat.taps_last = last_fc && last_fr && last_ch;
    assign stat.pos_last  = (pos_reg == 2'd3);

    // store writes and registered tap reads
    always_ff @(posedge clk)
    begin
        if (wr_img)
        begin
            img_mem[{in_channel, in_row, in_col}] <= in_value;
        end
        if (wr_ker)
        begin
            ker_mem[crm_pkg::KerAw'((in_channel * crm_pkg::MaxKernel + in_row)
                    * crm_pkg::MaxKernel + in_col)] <= in_value;
        end
        pix_reg <= img_mem[img_addr];
        wt_reg  <= ker_mem[ker_addr];
        prod_reg <= pix_reg * wt_reg;
    end

    // relu, scale and saturate of the finished sum
    logic [14:0] conv_val;
    always_comb
    begin
        if (acc_reg < 0)
            conv_val = '0;
        else if (acc_reg[47:14] > 34'sd32767)
            conv_val = 15'h7fff;
        else
            conv_val = acc_reg[28:14];
    end

    // counters, accumulator and running maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            pos_reg        <= '0;
            ch_reg         <= '0;
            fr_reg         <= '0;
            fc_reg         <= '0;
            best_any_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.tap_step && tap_in;
            prod_valid_reg <= rd_valid_reg;
            if (cmd.start)
            begin
                prow_reg     <= in_row;
                pcol_reg     <= in_col;
                pos_reg      <= '0;
                best_any_reg <= 1'b0;
            end
            if (cmd.pos_init)
            begin
                acc_reg <= 48'(bias);
                ch_reg  <= '0;
                fr_reg  <= '0;
                fc_reg  <= '0;
            end
            if (cmd.tap_step)
            begin
                if (!last_fc)
                    fc_reg <= fc_reg + 3'd1;
                else
                begin
                    fc_reg <= '0;
                    if (!last_fr)
                        fr_reg <= fr_reg + 3'd1;
                    else
                    begin
                        fr_reg <= '0;
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
            end
            if (cmd.mac && prod_valid_reg)
            begin
                acc_reg <= acc_reg + 48'(prod_reg);
            end
            if (cmd.pos_done)
            begin
                if (!best_any_reg || conv_val > best_reg)
                begin
                    best_reg     <= conv_val;
                    best_idx_reg <= {1'b0, pos_reg} + 3'd1;
                end
                best_any_reg <= 1'b1;
                pos_reg      <= pos_reg + 2'd1;
            end
            if (cmd.out_load)
            begin
                max_value_reg <= best_reg;
                max_index_reg <= best_idx_reg;
            end
        end
    end

    assign max_value = max_value_reg;
    assign max_index = max_index_reg;

endmodule

// ===== sv/crm_ctrl.sv =====
// controller: request decode and sequencing of taps, positions and result
// depends on crm_pkg
module crm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_kind,
    input  logic [1:0]          in_channel,
    input  logic [4:0]          in_row,
    input  logic [4:0]          in_col,
    input  logic [5:0]          rows,
    input  logic [5:0]          cols,
    input  logic [2:0]          chans,
    input  logic [2:0]          ksize,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                wr_img,
    output logic                wr_ker,
    output crm_pkg::crm_cmd_t   cmd,
    input  crm_pkg::crm_stat_t  stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_TAPS  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] drain_reg, drain_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, in_ch_ok, pool_ok, no_taps;

    // request accepted while idle; a held result only blocks the output load
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_ch_ok = ({1'b0, in_channel} < chans);
    assign wr_ker = accept && (in_kind == crm_pkg::KIND_WEIGHT) && in_ch_ok
                 && (in_row < {2'b0, ksize}) && (in_col < {2'b0, ksize});
    assign wr_img = accept && (in_kind == crm_pkg::KIND_PIXEL) && in_ch_ok
                 && ({1'b0, in_row} < rows) && ({1'b0, in_col} < cols);
    assign pool_ok = ({1'b0, in_row} < (rows >> 1)) && ({1'b0, in_col} < (cols >> 1));
    // no channel or no kernel tap: each sum is the bias alone
    assign no_taps = (chans == 3'd0) || (ksize == 3'd0);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_kind == crm_pkg::KIND_POOL && pool_ok)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.pos_init = 1'b1;
                state_next   = no_taps ? ST_DONE : ST_TAPS;
            end
            ST_TAPS:
            begin
                cmd.tap_step = 1'b1;
                cmd.mac      = 1'b1;
                if (stat.taps_last)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // read and multiply stages still in flight
                cmd.mac    = 1'b1;
                drain_next = drain_reg + 2'd1;
                if (drain_reg == 2'd1)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.pos_done = 1'b1;
                state_next   = stat.pos_last ? ST_OUT : ST_INIT;
            end
            ST_OUT:
            begin
                // wait until the output register is free or being emptied
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/conv_relu_maxpool_unit.sv =====
// top level: configuration registers, controller and datapath
// depends on crm_pkg, crm_ctrl, crm_datapath
//
// One convolution filter with same padding, ReLU and 2x2 max pooling. Weight
// and pixel requests give no result. A pool request is served by the single
// shared multiply-accumulate, which visits every kernel tap of each of the
// four positions in turn (taps outside the map add nothing). With no channel
// or a kernel size of zero the tap and drain states are skipped. Requests are
// still taken while a result waits; a finished pool request then waits for
// the output register.
module conv_relu_maxpool_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel[1:0], row[6:2], col[11:7], value[27:12]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // max_value[14:0], max_index[17:15]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [31:0] bias_reg;
    logic [5:0]  rows_reg, cols_reg;
    logic [2:0]  chans_reg, ksize_reg;
    logic [5:0]  rows, cols;
    logic [2:0]  chans, ksize;
    logic        wr_img, wr_ker;
    crm_pkg::crm_cmd_t  cmd;
    crm_pkg::crm_stat_t stat;
    logic [14:0] max_value;
    logic [2:0]  max_index;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg  <= '0;
            rows_reg  <= 6'd32;
            cols_reg  <= 6'd32;
            chans_reg <= 3'd1;
            ksize_reg <= 3'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crm_pkg::REG_BIAS:     bias_reg  <= cfg_data;
                crm_pkg::REG_ROWS:     rows_reg  <= cfg_data[5:0];
                crm_pkg::REG_COLS:     cols_reg  <= cfg_data[5:0];
                crm_pkg::REG_CHANNELS: chans_reg <= cfg_data[2:0];
                crm_pkg::REG_KERNEL:   ksize_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // sizes clamped to storage
    assign rows  = (rows_reg > 6'd32) ? 6'd32 : rows_reg;
    assign cols  = (cols_reg > 6'd32) ? 6'd32 : cols_reg;
    assign chans = (chans_reg > 3'd4) ? 3'd4 : chans_reg;
    assign ksize = (ksize_reg > 3'd5) ? 3'd5 : ksize_reg;

    crm_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_kind(s_tuser),
        .in_channel(s_tdata[1:0]), .in_row(s_tdata[6:2]), .in_col(s_tdata[11:7]),
        .rows(rows), .cols(cols), .chans(chans), .ksize(ksize),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .wr_img(wr_img), .wr_ker(wr_ker), .cmd(cmd), .stat(stat)
    );

    crm_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .wr_img(wr_img), .wr_ker(wr_ker),
        .in_channel(s_tdata[1:0]), .in_row(s_tdata[6:2]), .in_col(s_tdata[11:7]),
        .in_value(s_tdata[27:12]),
        .bias(bias_reg), .rows(rows), .cols(cols), .chans(chans), .ksize(ksize),
        .max_value(max_value), .max_index(max_index)
    );

    assign m_tdata = {6'b0, max_index, max_value};

    // checks
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:15] >= 3'd1 && m_tdata[17:15] <= 3'd4))
        else $error("max index out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("held result changed before it was taken");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_img || wr_ker) |-> s_tready)
        else $error("store write outside accept");

endmodule

// ===== verif/conv_relu_maxpool_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for conv_relu_maxpool_unit: directed table, then random phases
// depends on crm_pkg and the conv_relu_maxpool_unit rtl
module conv_relu_maxpool_unit_tb;

    localparam int HalfPeriod  = 5;
    localparam int IdleMax     = 16;
    localparam int DrainCycles = 450;
    localparam int CycleLimit  = 2_000_000;
    localparam int HoldCycles  = 600;
    localparam int HoldAfter   = 20;
    localparam int ItemTarget  = 1500;

    typedef struct {
        logic [1:0]         kind;
        logic [1:0]         channel;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] value;
    } request_t;

    typedef struct {
        logic [14:0] max_value;
        logic [2:0]  max_index;
    } pool_result_t;

    typedef struct {
        request_t     req;
        bit           typed;
        pool_result_t want;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    logic signed [15:0] pixel_mem [crm_pkg::ImgDepth];
    logic signed [15:0] weight_mem [crm_pkg::KerDepth];
    bit                 pixel_set [crm_pkg::ImgDepth];
    bit                 weight_set [crm_pkg::KerDepth];
    longint             bias_q22;
    int                 rows_reg;
    int                 cols_reg;
    int                 chans_reg;
    int                 ksize_reg;

    pool_result_t pending_pools [$];
    int           errors;
    int           items_sent;
    int           results_seen;
    int           cycles;
    bit           idle_on;

    conv_relu_maxpool_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #HalfPeriod clk = ~clk;
    end

    function automatic int clamp_to(int v, int hi);
        return (v > hi) ? hi : v;
    endfunction

    // relu output in unsigned q7.8 at one map position, flags any read of an unwritten entry
    function automatic logic [14:0] relu_at(int r, int c, inout bit clean);
        longint acc;
        int     rows_e;
        int     cols_e;
        int     chans_e;
        int     k_e;
        int     half;
        int     rr;
        int     cc;
        int     pi;
        int     wi;
        acc     = bias_q22;
        rows_e  = clamp_to(rows_reg, crm_pkg::MaxRows);
        cols_e  = clamp_to(cols_reg, crm_pkg::MaxCols);
        chans_e = clamp_to(chans_reg, crm_pkg::MaxChannels);
        k_e     = clamp_to(ksize_reg, crm_pkg::MaxKernel);
        half    = k_e / 2;
        for (int ch = 0; ch < chans_e; ch++)
        begin
            for (int fr = 0; fr < k_e; fr++)
            begin
                rr = r + fr - half;
                if (rr < 0 || rr >= rows_e)
                    continue;
                for (int fc = 0; fc < k_e; fc++)
                begin
                    cc = c + fc - half;
                    if (cc < 0 || cc >= cols_e)
                        continue;
                    pi = (ch * crm_pkg::MaxRows + rr) * crm_pkg::MaxCols + cc;
                    wi = (ch * crm_pkg::MaxKernel + fr) * crm_pkg::MaxKernel + fc;
                    if (!pixel_set[pi] || !weight_set[wi])
                        clean = 1'b0;
                    acc += longint'(pixel_mem[pi]) * longint'(weight_mem[wi]);
                end
            end
        end
        if (acc < 0)
            return '0;
        acc = acc >>> 14;
        if (acc > 32767)
            acc = 32767;
        return acc[14:0];
    endfunction

    // 2x2 maximum with argmax, earliest position wins ties; 0 when out of range
    function automatic bit pool_predict(int prow, int pcol, output pool_result_t res,
                                        output bit clean);
        int          best;
        logic [14:0] v;
        best  = -1;
        clean = 1'b1;
        res   = '{max_value: '0, max_index: '0};
        if (prow >= clamp_to(rows_reg, crm_pkg::MaxRows) / 2
            || pcol >= clamp_to(cols_reg, crm_pkg::MaxCols) / 2)
            return 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            v = relu_at(2 * prow + i / 2, 2 * pcol + i % 2, clean);
            if (best < int'(v))
            begin
                best          = int'(v);
                res.max_value = v;
                res.max_index = 3'(i + 1);
            end
        end
        return 1'b1;
    endfunction

    function automatic bit pool_safe(int prow, int pcol);
        pool_result_t res;
        bit           clean;
        void'(pool_predict(prow, pcol, res, clean));
        return clean;
    endfunction

    // apply one accepted request to the predictor and queue any result
    task automatic absorb(request_t rq, bit typed, pool_result_t want);
        pool_result_t res;
        bit           clean;
        int           chans_e;
        int           k_e;
        int           idx;
        chans_e = clamp_to(chans_reg, crm_pkg::MaxChannels);
        k_e     = clamp_to(ksize_reg, crm_pkg::MaxKernel);
        case (rq.kind)
            crm_pkg::KIND_WEIGHT:
                if (rq.channel < chans_e && rq.row < k_e && rq.col < k_e)
                begin
                    idx = (rq.channel * crm_pkg::MaxKernel + rq.row) * crm_pkg::MaxKernel
                          + rq.col;
                    weight_mem[idx] = rq.value;
                    weight_set[idx] = 1'b1;
                end
            crm_pkg::KIND_PIXEL:
                if (rq.channel < chans_e && rq.row < clamp_to(rows_reg, crm_pkg::MaxRows)
                    && rq.col < clamp_to(cols_reg, crm_pkg::MaxCols))
                begin
                    idx = (rq.channel * crm_pkg::MaxRows + rq.row) * crm_pkg::MaxCols
                          + rq.col;
                    pixel_mem[idx] = rq.value;
                    pixel_set[idx] = 1'b1;
                end
            crm_pkg::KIND_POOL:
                if (pool_predict(rq.row, rq.col, res, clean))
                    pending_pools.push_back(typed ? want : res);
            default: ;
        endcase
    endtask

    // offer one request after a random gap and wait for it to be taken
    task automatic send(request_t rq, bit typed = 1'b0,
                        pool_result_t want = '{max_value: '0, max_index: '0});
        int gap;
        gap = idle_on ? $urandom_range(0, IdleMax) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= rq.kind;
        s_tdata  <= {4'b0, rq.value, rq.col, rq.row, rq.channel};
        do
            @(posedge clk);
        while (!s_tready);
        absorb(rq, typed, want);
        items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            crm_pkg::REG_BIAS:     bias_q22  = longint'($signed(data));
            crm_pkg::REG_ROWS:     rows_reg  = int'(data[5:0]);
            crm_pkg::REG_COLS:     cols_reg  = int'(data[5:0]);
            crm_pkg::REG_CHANNELS: chans_reg = int'(data[2:0]);
            crm_pkg::REG_KERNEL:   ksize_reg = int'(data[2:0]);
            default: ;
        endcase
    endtask

    // hold the stream until all results are back and the block has gone quiet
    task automatic settle_and_configure(int rows, int cols, int chans, int k, logic [31:0] bias);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_pools.size() == 0);
        repeat (DrainCycles) @(posedge clk);
        write_reg(crm_pkg::REG_BIAS, bias);
        write_reg(crm_pkg::REG_ROWS, 32'(rows));
        write_reg(crm_pkg::REG_COLS, 32'(cols));
        write_reg(crm_pkg::REG_CHANNELS, 32'(chans));
        write_reg(crm_pkg::REG_KERNEL, 32'(k));
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic logic [31:0] rand_bias();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return $urandom;
            default: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic request_t noise_item();
        request_t rq;
        rq.kind    = $urandom_range(0, 1) ? 2'd3 : 2'($urandom_range(0, 1));
        rq.channel = 2'($urandom);
        rq.row     = 5'($urandom);
        rq.col     = 5'($urandom);
        rq.value   = 16'($urandom);
        return rq;
    endfunction

    // one well-formed pass: full kernel, full map, then pool requests, with noise
    task automatic run_phase(int nreq);
        request_t rq;
        int       chans_e;
        int       k_e;
        int       rows_e;
        int       cols_e;
        chans_e = clamp_to(chans_reg, crm_pkg::MaxChannels);
        k_e     = clamp_to(ksize_reg, crm_pkg::MaxKernel);
        rows_e  = clamp_to(rows_reg, crm_pkg::MaxRows);
        cols_e  = clamp_to(cols_reg, crm_pkg::MaxCols);
        for (int ch = 0; ch < chans_e; ch++)
            for (int r = 0; r < k_e; r++)
                for (int c = 0; c < k_e; c++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send(noise_item());
                    rq = '{crm_pkg::KIND_WEIGHT, 2'(ch), 5'(r), 5'(c), rand_value()};
                    send(rq);
                end
        for (int ch = 0; ch < chans_e; ch++)
            for (int r = 0; r < rows_e; r++)
                for (int c = 0; c < cols_e; c++)
                begin
                    rq = '{crm_pkg::KIND_PIXEL, 2'(ch), 5'(r), 5'(c), rand_value()};
                    send(rq);
                end
        for (int n = 0; n < nreq; n++)
        begin
            case ($urandom_range(0, 9))
                0:       rq = noise_item();
                1:       rq = '{crm_pkg::KIND_POOL, 2'($urandom), 5'($urandom), 5'($urandom),
                                16'($urandom)};
                2:       rq = '{crm_pkg::KIND_PIXEL,
                                2'($urandom_range(0, chans_e > 0 ? chans_e - 1 : 0)),
                                5'($urandom_range(0, rows_e > 0 ? rows_e - 1 : 0)),
                                5'($urandom_range(0, cols_e > 0 ? cols_e - 1 : 0)), rand_value()};
                default: rq = '{crm_pkg::KIND_POOL, 2'($urandom),
                                5'($urandom_range(0, rows_e / 2 > 0 ? rows_e / 2 - 1 : 0)),
                                5'($urandom_range(0, cols_e / 2 > 0 ? cols_e / 2 - 1 : 0)),
                                16'($urandom)};
            endcase
            // never read an entry that was not written
            if (rq.kind == crm_pkg::KIND_POOL && !pool_safe(rq.row, rq.col))
                continue;
            // a pixel rewrite is harmless only where it is in the map
            if (rq.kind == crm_pkg::KIND_PIXEL && rq.channel < chans_e && rq.row < rows_e
                && rq.col < cols_e)
                send(rq);
            else if (rq.kind != crm_pkg::KIND_PIXEL)
                send(rq);
        end
    endtask

    // directed table: tiny 2x2 map, 1x1 kernel of unit weight
    table_row_t directed [] = '{
        '{'{crm_pkg::KIND_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sd16384}, 1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_PIXEL,  2'd0, 5'd0, 5'd0, 16'sd100},   1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_PIXEL,  2'd0, 5'd0, 5'd1, 16'sd300},   1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_PIXEL,  2'd0, 5'd1, 5'd0, 16'sd300},   1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_PIXEL,  2'd0, 5'd1, 5'd1, -16'sd5},    1'b0, '{15'd0, 3'd0}},
        // tie between top-right and bottom-left goes to top-right
        '{'{crm_pkg::KIND_POOL,   2'd0, 5'd0, 5'd0, 16'sd0},     1'b1, '{15'd300, 3'd2}},
        // pooled position beyond the grid, no result
        '{'{crm_pkg::KIND_POOL,   2'd0, 5'd1, 5'd0, 16'sd0},     1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_POOL,   2'd3, 5'd31, 5'd31, 16'hffff}, 1'b0, '{15'd0, 3'd0}},
        '{'{2'd3,                 2'd0, 5'd0, 5'd0, 16'sd0},     1'b0, '{15'd0, 3'd0}},
        // most negative weight: only the negative pixel survives relu
        '{'{crm_pkg::KIND_PIXEL,  2'd0, 5'd0, 5'd0, 16'sh7fff},  1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sh8000},  1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_POOL,   2'd0, 5'd0, 5'd0, 16'sd0},     1'b1, '{15'd10, 3'd4}},
        // most positive weight: saturates, first position wins
        '{'{crm_pkg::KIND_WEIGHT, 2'd0, 5'd0, 5'd0, 16'sh7fff},  1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_PIXEL,  2'd0, 5'd1, 5'd1, 16'sh7fff},  1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_POOL,   2'd0, 5'd0, 5'd0, 16'sd0},     1'b1, '{15'd32767, 3'd1}},
        // writes outside the sizes in use are dropped
        '{'{crm_pkg::KIND_WEIGHT, 2'd3, 5'd4, 5'd4, 16'sd0},     1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_WEIGHT, 2'd0, 5'd1, 5'd0, 16'sd0},     1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_PIXEL,  2'd3, 5'd31, 5'd31, 16'sd0},   1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_PIXEL,  2'd0, 5'd2, 5'd0, 16'sd0},     1'b0, '{15'd0, 3'd0}},
        '{'{crm_pkg::KIND_POOL,   2'd0, 5'd0, 5'd0, 16'sd0},     1'b1, '{15'd32767, 3'd1}}
    };

    // result checker with random back-pressure and one long hold
    initial
    begin
        int  stall;
        bit  held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= HoldAfter)
            begin
                held  = 1'b1;
                stall = HoldCycles;
            end
            else
                stall = idle_on ? $urandom_range(0, IdleMax) : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen++;
            if (pending_pools.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result max_value=%0d max_index=%0d", $time,
                         m_tdata[14:0], m_tdata[17:15]);
            end
            else
            begin
                pool_result_t want;
                want = pending_pools.pop_front();
                if (m_tdata[14:0] !== want.max_value)
                begin
                    errors++;
                    $display("%0t: max_value expected %0d actual %0d", $time,
                             want.max_value, m_tdata[14:0]);
                end
                if (m_tdata[17:15] !== want.max_index)
                begin
                    errors++;
                    $display("%0t: max_index expected %0d actual %0d", $time,
                             want.max_index, m_tdata[17:15]);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int rows;
        int cols;
        int chans;
        errors     = 0;
        items_sent = 0;
        results_seen = 0;
        cycles     = 0;
        idle_on    = 1'b1;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        bias_q22   = 0;
        rows_reg   = 32;
        cols_reg   = 32;
        chans_reg  = 1;
        ksize_reg  = 3;
        for (int i = 0; i < crm_pkg::ImgDepth; i++)
        begin
            pixel_mem[i] = '0;
            pixel_set[i] = 1'b0;
        end
        for (int i = 0; i < crm_pkg::KerDepth; i++)
        begin
            weight_mem[i] = '0;
            weight_set[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        settle_and_configure(2, 2, 1, 1, 32'h0);
        foreach (directed[i])
            send(directed[i].req, directed[i].typed, directed[i].want);

        // largest map with the largest kernel, long receiver hold lands here
        settle_and_configure(32, 32, 1, 5, rand_bias());
        run_phase(40);
        // most work per request: all channels, largest kernel
        settle_and_configure(4, 4, 4, 5, 32'h7fff_ffff);
        run_phase(12);
        settle_and_configure(6, 4, 2, 2, 32'h8000_0000);
        run_phase(12);

        while (items_sent < ItemTarget)
        begin
            rows  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 10);
            cols  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 10);
            chans = $urandom_range(0, 7);
            if (clamp_to(rows, crm_pkg::MaxRows) * clamp_to(cols, crm_pkg::MaxCols)
                * clamp_to(chans, crm_pkg::MaxChannels) > 200)
            begin
                chans = 1;
                cols  = $urandom_range(2, 6);
            end
            idle_on = ($urandom_range(0, 3) != 0);
            settle_and_configure(rows, cols, chans, $urandom_range(0, 7), rand_bias());
            run_phase($urandom_range(15, 40));
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_pools.size() == 0);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
